@@ hw/rtl/dtl_pkg.sv @@
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared codes and types for the dual table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package dtl_pkg;

	typedef enum logic [1:0] {
		FUNC_EVAL     = 2'd0,
		FUNC_WR_WATER = 2'd1,
		FUNC_WR_OIL   = 2'd2
	} func_t;

	localparam logic [1:0] CFG_X_ORIGIN = 2'd0;
	localparam logic [1:0] CFG_STEP     = 2'd1;
	localparam logic [1:0] CFG_LENGTH   = 2'd2;

	typedef struct packed {
		logic wr_water;
		logic wr_oil;
		logic rd;
	} mem_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/dtl_div.sv @@
// ----------------------------------------------------------------------------
// dtl_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module dtl_div #(
	parameter int NW = 32,
	parameter int DW = 31,
	parameter int QW = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [QW-1:0]      out_quot,
	output logic [DW-1:0]      out_rem,
	output logic [SW-1:0]      out_side
);

	localparam int RW = DW + QW;

	logic          vld_st  [QW];
	logic [RW-1:0] rem_st  [QW];
	logic [DW-1:0] den_st  [QW];
	logic [QW-1:0] quo_st  [QW];
	logic [SW-1:0] side_st [QW];

	for (genvar j = 0; j < QW; j++) begin : g_st
		localparam int K = QW - 1 - j;
		logic          v_in;
		logic [RW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [SW-1:0] s_in;
		logic [RW:0]   trial;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = RW'(in_num);
			assign d_in = in_den;
			assign q_in = '0;
			assign s_in = in_side;
		end else begin : g_next
			assign v_in = vld_st[j-1];
			assign r_in = rem_st[j-1];
			assign d_in = den_st[j-1];
			assign q_in = quo_st[j-1];
			assign s_in = side_st[j-1];
		end

		assign trial = {1'b0, r_in} - ((RW+1)'(d_in) << K);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_st[j] <= 1'b0;
			end else if (en) begin
				vld_st[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[j]  <= trial[RW] ? r_in : trial[RW-1:0];
				quo_st[j]  <= {q_in[QW-2:0], ~trial[RW]};
				den_st[j]  <= d_in;
				side_st[j] <= s_in;
			end
		end
	end

	assign out_valid = vld_st[QW-1];
	assign out_quot  = quo_st[QW-1];
	assign out_rem   = rem_st[QW-1][DW-1:0];
	assign out_side  = side_st[QW-1];

endmodule
`default_nettype wire

@@ hw/rtl/dtl_tables.sv @@
// ----------------------------------------------------------------------------
// dtl_tables
// Water and oil table memories: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module dtl_tables #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic              clk,
	input  wire dtl_pkg::mem_ctl_t ctl,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [31:0]       wr_data,
	input  wire logic [AW-1:0]     rd_lo_addr,
	input  wire logic [AW-1:0]     rd_hi_addr,
	output logic [31:0]            water_lo,
	output logic [31:0]            water_hi,
	output logic [31:0]            oil_lo,
	output logic [31:0]            oil_hi
);

	logic [31:0] water_mem [DEPTH];
	logic [31:0] oil_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_water) begin
			water_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			water_lo <= water_mem[rd_lo_addr];
			water_hi <= water_mem[rd_hi_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_oil) begin
			oil_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			oil_lo <= oil_mem[rd_lo_addr];
			oil_hi <= oil_mem[rd_hi_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/dual_table_lerp_with_slope.sv @@
// ----------------------------------------------------------------------------
// dual_table_lerp_with_slope
// Path: segment divider, table read with stage s2, stages s3 to s6, value and slope dividers, output register.
// Throughput: one beat per cycle while the result side does not stall; set by the one-bit-per-stage dividers.
// A stall on the result side freezes the whole pipeline.
// Reset clears pipeline valids and loads register defaults; tables are
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_table_lerp_with_slope #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [71:0]  s_tdata,  // entry_index, entry_value, sample
	input  wire logic [1:0]   s_tuser,  // func
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,  // water_value, oil_value, water_slope, oil_slope
	output logic              m_tlast
);

	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NLW = $clog2(TABLE_DEPTH + 1);
	localparam int QW  = 49;

	// floor of a signed quotient from the magnitude quotient and remainder
	function automatic logic signed [49:0] fix_round(input logic [QW-1:0] q,
		input logic r_nz, input logic neg);
		logic signed [49:0] t;
		t = $signed({1'b0, q}) + $signed({49'b0, r_nz && neg});
		fix_round = neg ? -t : t;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sh7FFFFFFF) sat32 = 32'h7FFFFFFF;
		else if (v < 50'sh3FFFF80000000) sat32 = 32'h80000000;
		else sat32 = v[31:0];
	endfunction

	logic [31:0] x_origin_q;
	logic [30:0] step_q;
	logic [8:0]  length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			step_q     <= 31'd65536;
			length_q   <= 9'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				dtl_pkg::CFG_X_ORIGIN: x_origin_q <= cfg_wdata;
				dtl_pkg::CFG_STEP:     step_q     <= cfg_wdata[30:0];
				dtl_pkg::CFG_LENGTH:   length_q   <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	logic [30:0]    h;
	logic [NLW-1:0] n_eff, nm1, nm2;
	logic signed [50:0] h51;
	logic signed [65:0] h66;

	always_comb begin
		h = (step_q == '0) ? 31'd1 : step_q;
		if (length_q < 9'd2) n_eff = NLW'(2);
		else if (32'(length_q) > TABLE_DEPTH) n_eff = NLW'(TABLE_DEPTH);
		else n_eff = NLW'(length_q);
		nm1 = n_eff - NLW'(1);
		nm2 = n_eff - NLW'(2);
		h51 = $signed({20'b0, h});
		h66 = $signed({35'b0, h});
	end

	logic en;
	logic m_tvalid_q;
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// accept: offset from origin, segment divide
	logic signed [32:0] d_off;
	logic               below;
	assign d_off = $signed({s_tdata[71], s_tdata[71:40]})
	             - $signed({x_origin_q[31], x_origin_q});
	assign below = d_off[32];

	logic        sd_valid;
	logic [31:0] sd_seg;
	logic [30:0] sd_rem;
	logic [43:0] sd_side;

	dtl_div #(.NW(32), .DW(31), .QW(32), .SW(44)) u_seg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid && en),
		.in_num   (below ? 32'd0 : d_off[31:0]),
		.in_den   (h),
		.in_side  ({below, s_tlast, s_tuser, s_tdata[7:0], s_tdata[39:8]}),
		.out_valid(sd_valid),
		.out_quot (sd_seg),
		.out_rem  (sd_rem),
		.out_side (sd_side)
	);

	logic        sd_below, sd_last;
	logic [1:0]  sd_func;
	logic [7:0]  sd_idx;
	logic [31:0] sd_wval;
	assign {sd_below, sd_last, sd_func, sd_idx, sd_wval} = sd_side;

	// table access
	logic              clamp, normal, idx_ok, is_eval;
	logic [IW-1:0]     lo_addr, hi_addr;
	dtl_pkg::mem_ctl_t mctl;

	always_comb begin
		clamp   = !sd_below && (sd_seg >= 32'(nm1));
		normal  = !sd_below && !clamp;
		if (sd_below) lo_addr = '0;
		else if (clamp) lo_addr = IW'(nm2);
		else lo_addr = sd_seg[IW-1:0];
		hi_addr = lo_addr + IW'(1);
		idx_ok  = 32'(sd_idx) < TABLE_DEPTH;
		is_eval = sd_func == dtl_pkg::FUNC_EVAL;
		mctl.wr_water = sd_valid && en && idx_ok && (sd_func == dtl_pkg::FUNC_WR_WATER);
		mctl.wr_oil   = sd_valid && en && idx_ok && (sd_func == dtl_pkg::FUNC_WR_OIL);
		mctl.rd       = sd_valid && en && is_eval;
	end

	logic [31:0] w_lo, w_hi, o_lo, o_hi;

	dtl_tables #(.DEPTH(TABLE_DEPTH), .AW(IW)) u_tables (
		.clk       (clk),
		.ctl       (mctl),
		.wr_addr   (IW'(sd_idx)),
		.wr_data   (sd_wval),
		.rd_lo_addr(lo_addr),
		.rd_hi_addr(hi_addr),
		.water_lo  (w_lo),
		.water_hi  (w_hi),
		.oil_lo    (o_lo),
		.oil_hi    (o_hi)
	);

	logic        valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic        clamp_s2, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [30:0] rem_s2, rem_s3;
	logic signed [32:0] dw_s3, do_s3, dw_s4, do_s4;
	logic [31:0] bw_s3, bo_s3, bw_s4, bo_s4, bw_s5, bo_s5, bw_s6, bo_s6;
	logic signed [49:0] pwl_s4, pol_s4;
	logic signed [48:0] pwh_s4, poh_s4;
	logic signed [64:0] pw_s5, po_s5;
	logic signed [50:0] nsw_s5, nso_s5, nsw_s6, nso_s6;
	logic signed [65:0] nvw_s6, nvo_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s2 <= sd_valid && is_eval;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s2 <= clamp;
			last_s2  <= sd_last;
			rem_s2   <= normal ? sd_rem : '0;

			dw_s3   <= $signed({w_hi[31], w_hi}) - $signed({w_lo[31], w_lo});
			do_s3   <= $signed({o_hi[31], o_hi}) - $signed({o_lo[31], o_lo});
			bw_s3   <= clamp_s2 ? w_hi : w_lo;
			bo_s3   <= clamp_s2 ? o_hi : o_lo;
			rem_s3  <= rem_s2;
			last_s3 <= last_s2;

			pwl_s4  <= dw_s3 * $signed({1'b0, rem_s3[15:0]});
			pwh_s4  <= dw_s3 * $signed({1'b0, rem_s3[30:16]});
			pol_s4  <= do_s3 * $signed({1'b0, rem_s3[15:0]});
			poh_s4  <= do_s3 * $signed({1'b0, rem_s3[30:16]});
			dw_s4   <= dw_s3;
			do_s4   <= do_s3;
			bw_s4   <= bw_s3;
			bo_s4   <= bo_s3;
			last_s4 <= last_s3;

			pw_s5   <= 65'(pwl_s4) + (65'(pwh_s4) <<< 16);
			po_s5   <= 65'(pol_s4) + (65'(poh_s4) <<< 16);
			nsw_s5  <= (51'(dw_s4) <<< 17) + h51;
			nso_s5  <= (51'(do_s4) <<< 17) + h51;
			bw_s5   <= bw_s4;
			bo_s5   <= bo_s4;
			last_s5 <= last_s4;

			nvw_s6  <= (66'(pw_s5) <<< 1) + h66;
			nvo_s6  <= (66'(po_s5) <<< 1) + h66;
			nsw_s6  <= nsw_s5;
			nso_s6  <= nso_s5;
			bw_s6   <= bw_s5;
			bo_s6   <= bo_s5;
			last_s6 <= last_s5;
		end
	end

	// rounded divides by 2h on magnitudes
	logic [65:0] mvw, mvo;
	logic [50:0] msw, mso;
	assign mvw = nvw_s6[65] ? -nvw_s6 : nvw_s6;
	assign mvo = nvo_s6[65] ? -nvo_s6 : nvo_s6;
	assign msw = nsw_s6[50] ? -nsw_s6 : nsw_s6;
	assign mso = nso_s6[50] ? -nso_s6 : nso_s6;

	logic          vw_valid, vo_valid, sw_valid, so_valid;
	logic [QW-1:0] vw_q, vo_q, sw_q, so_q;
	logic [31:0]   vw_r, vo_r, sw_r, so_r;
	logic [65:0]   vw_side;
	logic          vo_neg, sw_neg, so_neg;

	dtl_div #(.NW(65), .DW(32), .QW(QW), .SW(66)) u_wv_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s6),
		.in_num(mvw[64:0]), .in_den({h, 1'b0}),
		.in_side({last_s6, bo_s6, bw_s6, nvw_s6[65]}),
		.out_valid(vw_valid), .out_quot(vw_q), .out_rem(vw_r), .out_side(vw_side)
	);

	dtl_div #(.NW(65), .DW(32), .QW(QW), .SW(1)) u_ov_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s6),
		.in_num(mvo[64:0]), .in_den({h, 1'b0}), .in_side(nvo_s6[65]),
		.out_valid(vo_valid), .out_quot(vo_q), .out_rem(vo_r), .out_side(vo_neg)
	);

	dtl_div #(.NW(50), .DW(32), .QW(QW), .SW(1)) u_ws_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s6),
		.in_num(msw[49:0]), .in_den({h, 1'b0}), .in_side(nsw_s6[50]),
		.out_valid(sw_valid), .out_quot(sw_q), .out_rem(sw_r), .out_side(sw_neg)
	);

	dtl_div #(.NW(50), .DW(32), .QW(QW), .SW(1)) u_os_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(valid_s6),
		.in_num(mso[49:0]), .in_den({h, 1'b0}), .in_side(nso_s6[50]),
		.out_valid(so_valid), .out_quot(so_q), .out_rem(so_r), .out_side(so_neg)
	);

	logic        res_valid;
	logic [31:0] wv_res, ov_res, ws_res, os_res;
	logic signed [49:0] qwv, qov, qws, qos;

	always_comb begin
		res_valid = vw_valid && vo_valid && sw_valid && so_valid;
		qwv    = fix_round(vw_q, vw_r != '0, vw_side[0]);
		qov    = fix_round(vo_q, vo_r != '0, vo_neg);
		qws    = fix_round(sw_q, sw_r != '0, sw_neg);
		qos    = fix_round(so_q, so_r != '0, so_neg);
		wv_res = vw_side[32:1] + qwv[31:0];
		ov_res = vw_side[64:33] + qov[31:0];
		ws_res = sat32(qws);
		os_res = sat32(qos);
	end

	logic [127:0] m_tdata_q;
	logic         m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_valid) begin
			m_tdata_q <= {os_res, ws_res, ov_res, wv_res};
			m_tlast_q <= vw_side[65];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual table interpolator. Tables are loaded
// beat by beat, then samples below, inside and past the tables are streamed
// through under bursty input and a stalling output. Every output beat is
// compared with a local model of value, slope and saturation. The bench runs
// several register settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

	localparam int         DEPTH      = 256;
	localparam int         LATENCY    = 87;
	localparam int         WD_LIMIT   = 5000;
	localparam logic [1:0] FUNC_NONE  = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [7:0]  idx;
		logic [31:0] val;
		logic [31:0] smp;
		logic        last;
	} beat_t;

	typedef struct {
		logic [31:0] wv;
		logic [31:0] ov;
		logic [31:0] ws;
		logic [31:0] os;
		logic        eob;
	} lerp_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = dtl_pkg::CFG_X_ORIGIN;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;  // entry_index, entry_value, sample
	logic [1:0]   s_tuser = dtl_pkg::FUNC_EVAL;  // func
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;  // water_value, oil_value, water_slope, oil_slope
	logic         m_tlast;

	dual_table_lerp_with_slope #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

	// model state
	int          water_mem [DEPTH];
	int          oil_mem [DEPTH];
	bit          water_set [DEPTH];
	bit          oil_set [DEPTH];
	int          x0_reg = 0;
	logic [30:0] step_reg = 31'd65536;
	logic [8:0]  len_reg = 9'd2;

	beat_t       pending_beats [$];
	lerp_res_t   expected_res [$];
	int          errors = 0;
	int          n_evals = 0, n_writes = 0, n_results = 0, n_phases = 0;
	bit          in_acc = 1'b0;
	int          idle_cycles = 0;

	initial forever #6 clk = ~clk;

	function automatic longint div_round(longint p, longint d);
		longint q, r;
		q = p / d;
		r = p % d;
		if (r < 0) begin
			q -= 1;
			r += d;
		end
		if (2 * r >= d) q += 1;
		return q;
	endfunction

	function automatic longint step_eff();
		return (step_reg == 0) ? 1 : longint'(step_reg);
	endfunction

	function automatic int len_eff();
		int n;
		n = int'(len_reg);
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		return n;
	endfunction

	function automatic void lerp_one(input bit oil, input bit below, input longint seg,
			input longint rem, output logic [31:0] v, output logic [31:0] s);
		longint h, diff, sl;
		int n, t0, t1;
		h = step_eff();
		n = len_eff();
		if (below) begin
			t0 = oil ? oil_mem[0] : water_mem[0];
			t1 = oil ? oil_mem[1] : water_mem[1];
			v = t0;
		end else if (seg >= n - 1) begin
			t0 = oil ? oil_mem[n-2] : water_mem[n-2];
			t1 = oil ? oil_mem[n-1] : water_mem[n-1];
			v = t1;
		end else begin
			t0 = oil ? oil_mem[seg] : water_mem[seg];
			t1 = oil ? oil_mem[seg+1] : water_mem[seg+1];
			v = 32'(longint'(t0) + div_round((longint'(t1) - longint'(t0)) * rem, h));
		end
		diff = longint'(t1) - longint'(t0);
		sl = div_round(diff * 65536, h);
		if (sl > 64'sd2147483647) sl = 64'sd2147483647;
		if (sl < -64'sd2147483648) sl = -64'sd2147483648;
		s = 32'(sl);
	endfunction

	function automatic lerp_res_t predict_lerp(logic [31:0] x, logic last);
		lerp_res_t r;
		longint d, seg, rem, h;
		bit below;
		h = step_eff();
		d = longint'($signed(x)) - longint'(x0_reg);
		below = d < 0;
		seg = 0;
		rem = 0;
		if (!below) begin
			seg = d / h;
			rem = d - seg * h;
		end
		lerp_one(1'b0, below, seg, rem, r.wv, r.ws);
		lerp_one(1'b1, below, seg, rem, r.ov, r.os);
		r.eob = last;
		return r;
	endfunction

	// input side: accept, update tables, predict
	always @(posedge clk) begin
		beat_t b;
		in_acc <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			b.func = s_tuser;
			{b.smp, b.val, b.idx} = s_tdata;
			b.last = s_tlast;
			case (b.func)
				dtl_pkg::FUNC_WR_WATER: begin
					water_mem[b.idx] = b.val;
					n_writes++;
				end
				dtl_pkg::FUNC_WR_OIL: begin
					oil_mem[b.idx] = b.val;
					n_writes++;
				end
				dtl_pkg::FUNC_EVAL: begin
					expected_res.push_back(predict_lerp(b.smp, b.last));
					n_evals++;
				end
				default: ;
			endcase
		end
	end

	// output side: compare
	always @(posedge clk) begin
		lerp_res_t e;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (expected_res.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (m_tdata[31:0] !== e.wv) begin
					$error("water_value exp %h got %h", e.wv, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.ov) begin
					$error("oil_value exp %h got %h", e.ov, m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== e.ws) begin
					$error("water_slope exp %h got %h", e.ws, m_tdata[95:64]);
					errors++;
				end
				if (m_tdata[127:96] !== e.os) begin
					$error("oil_slope exp %h got %h", e.os, m_tdata[127:96]);
					errors++;
				end
				if (m_tlast !== e.eob) begin
					$error("end_of_batch exp %b got %b", e.eob, m_tlast);
					errors++;
				end
			end
		end
	end

	// sender: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		beat_t b;
		bit nv;
		if (arst_n && !(s_tvalid && !in_acc)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				s_tdata <= {b.smp, b.val, b.idx};
				s_tuser <= b.func;
				s_tlast <= b.last;
				nv = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			s_tvalid <= nv;
		end
	end

	// receiver: own stall pattern plus one long hold-off
	int mode = 0, mode_left = 0, hold_left = 0;
	bit held = 1'b0;
	always @(negedge clk) begin
		bit rdy;
		if (!held && n_evals >= 20 && pending_beats.size() > 60) begin
			held = 1'b1;
			hold_left = 400;
		end
		if (mode_left == 0) begin
			mode = $urandom_range(0, 2);
			mode_left = $urandom_range(16, 128);
		end
		mode_left--;
		case (mode)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			default: rdy = ($urandom_range(0, 9) != 0);
		endcase
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end
		m_tready <= rdy;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			dtl_pkg::CFG_X_ORIGIN: x0_reg = data;
			dtl_pkg::CFG_STEP: step_reg = data[30:0];
			dtl_pkg::CFG_LENGTH: len_reg = data[8:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_beats.size() != 0 || s_tvalid || expected_res.size() != 0);
		repeat (LATENCY + 13) @(negedge clk);
	endtask

	task automatic add_beat(logic [1:0] f, logic [7:0] idx, logic [31:0] val,
			logic [31:0] smp, logic last);
		beat_t b;
		b.func = f;
		b.idx = idx;
		b.val = val;
		b.smp = smp;
		b.last = last;
		if (f == dtl_pkg::FUNC_WR_WATER) water_set[idx] = 1'b1;
		if (f == dtl_pkg::FUNC_WR_OIL) oil_set[idx] = 1'b1;
		pending_beats.push_back(b);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 65536 * 4)) - 32'd131072;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_sample();
		longint h, x;
		int n, k;
		h = step_eff();
		n = len_eff();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
			2: x = longint'(x0_reg) - $urandom_range(1, 200000);
			3: x = longint'(x0_reg) + longint'($urandom_range(0, n - 1)) * h;
			default: begin
				k = $urandom_range(0, n);
				x = longint'(x0_reg) + longint'(k) * h + $urandom_range(0, int'(h - 1));
			end
		endcase
		if (x > 64'sd2147483647) x = 64'sd2147483647;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		return 32'(x);
	endfunction

	task automatic fill_tables();
		int n;
		n = len_eff();
		for (int i = 0; i < n; i++) begin
			if (!water_set[i])
				add_beat(dtl_pkg::FUNC_WR_WATER, 8'(i), rand_word(), $urandom, 1'($urandom));
			if (!oil_set[i])
				add_beat(dtl_pkg::FUNC_WR_OIL, 8'(i), rand_word(), $urandom, 1'($urandom));
		end
	endtask

	task automatic random_beats(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 19);
			if (sel < 15)
				add_beat(dtl_pkg::FUNC_EVAL, 8'($urandom), $urandom, pick_sample(),
					1'($urandom));
			else if (sel < 17)
				add_beat(dtl_pkg::FUNC_WR_WATER, 8'($urandom), rand_word(), $urandom,
					1'($urandom));
			else if (sel < 19)
				add_beat(dtl_pkg::FUNC_WR_OIL, 8'($urandom), rand_word(), $urandom,
					1'($urandom));
			else add_beat(FUNC_NONE, 8'($urandom), $urandom, $urandom, 1'($urandom));
		end
		add_beat(dtl_pkg::FUNC_EVAL, 8'($urandom), $urandom, pick_sample(), 1'b1);
	endtask

	task automatic run_phase(logic [31:0] x0, logic [31:0] stp, logic [31:0] len, int count);
		reg_write(dtl_pkg::CFG_X_ORIGIN, x0);
		reg_write(dtl_pkg::CFG_STEP, stp);
		reg_write(dtl_pkg::CFG_LENGTH, len);
		fill_tables();
		random_beats(count);
		wait_drained();
		n_phases++;
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// directed: default registers, entries 0, 1 and 255 in each table
		add_beat(dtl_pkg::FUNC_WR_WATER, 8'd0, 32'h80000000, 32'h0, 1'b0);
		add_beat(dtl_pkg::FUNC_WR_WATER, 8'd1, 32'h7fffffff, 32'h0, 1'b0);
		add_beat(dtl_pkg::FUNC_WR_OIL, 8'd0, 32'h00010000, 32'h0, 1'b0);
		add_beat(dtl_pkg::FUNC_WR_OIL, 8'd1, 32'hfffe0000, 32'h0, 1'b0);
		add_beat(dtl_pkg::FUNC_WR_WATER, 8'd255, 32'h12345678, 32'hffffffff, 1'b1);
		add_beat(dtl_pkg::FUNC_WR_OIL, 8'd255, 32'hedcba987, 32'h0, 1'b0);
		add_beat(FUNC_NONE, 8'hff, 32'hffffffff, 32'hffffffff, 1'b1);
		add_beat(dtl_pkg::FUNC_EVAL, 8'hff, 32'hffffffff, 32'h80000000, 1'b0);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h7fffffff, 1'b1);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h00000000, 1'b0);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'hffffffff, 1'b0);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h00008000, 1'b1);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h00007fff, 1'b0);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h00010000, 1'b0);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h0000ffff, 1'b1);
		add_beat(dtl_pkg::FUNC_EVAL, 8'h00, 32'h0, 32'h00020000, 1'b0);
		wait_drained();
		reg_write(CFG_UNUSED, 32'hffffffff);
		n_phases++;

		// tiny step, full tables: slopes saturate
		run_phase(32'hfff0bdc0, 32'd3, 32'd256, 120);
		// extreme origin and step
		run_phase(32'h80000000, 32'h7fffffff, 32'd5, 40);
		// zero step, length below minimum
		run_phase(32'h00012345, 32'd0, 32'd1, 30);
		run_phase(32'h00000000, 32'd65536, 32'd0, 20);
		// length above depth, top step bit ignored
		run_phase(32'h7fffffff, 32'h80010000, 32'h1ff, 40);
		run_phase($urandom, $urandom_range(1, 1 << 20), 32'd300, 40);
		for (int p = 0; p < 3; p++)
			run_phase($urandom, $urandom_range(1, 1 << 22), $urandom_range(2, 40), 25);

		$display("covered %0d phases: %0d samples, %0d table writes, %0d results",
			n_phases, n_evals, n_writes, n_results);
		$display("register extremes, clamped length and step, saturated slopes, long stall");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
